@@ sv/matrix_multiply_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply engine
// Concurrent checks, sampled on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// same-cycle implication
`define MME_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// Types, constants and helpers shared by the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int ADDR_W    = 2 * DIM_W;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
   localparam int DIM_REG_W = 4;
   localparam int CSR_IDX_W = 2;

   typedef logic [DIM_W-1:0]     idx_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [DIM_REG_W-1:0] dim_reg_type;

   localparam logic [1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS    = 2'd2;

   // last valid index for a dimension register: zero acts as one, clamp at MAX_DIM
   function automatic idx_type dim_last(input dim_reg_type v);
      dim_reg_type m1;
      m1 = v - dim_reg_type'(1);
      if (v == '0) begin
         return '0;
      end else if (v > dim_reg_type'(MAX_DIM)) begin
         return idx_type'(MAX_DIM - 1);
      end else begin
         return m1[DIM_W-1:0];
      end
   endfunction

endpackage

@@ sv/mme_ram.sv @@
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// General matrix multiply on signed Q16.16 elements held in two local stores.
// ----------------------------------------------------------------------------
// A load (start with req_type A or B) leaves busy low; an out-of-range load
// answers with one error word on the following cycle. A compute holds busy
// high until the last product entry is emitted: each product term steps
// through store read, shared 32x32 multiply and accumulate, and each product
// entry then has an output step to emit it. Result words appear on rsp_* for
// exactly one cycle, marked by rsp_valid, and cannot be held off. Both stores
// read as zero after reset until written.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine
   import mme_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic [DIM_W-1:0]         req_elem_row,
   input  logic [DIM_W-1:0]         req_elem_col,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   output logic                     rsp_valid,
   output logic [DIM_W-1:0]         rsp_out_row,
   output logic [DIM_W-1:0]         rsp_out_col,
   output logic signed [ELEM_W-1:0] rsp_out_value,
   output logic                     rsp_last_flag,
   output logic                     rsp_index_error,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_REG_W-1:0]     csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam int SH_W = ACC_W - FRAC_BITS;

   logic [2:0]               state_ff, state_in;
   dim_reg_type              a_rows_ff, inner_dim_ff, b_cols_ff;
   idx_type                  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [DEPTH-1:0]         a_valid_ff, b_valid_ff;
   logic                     a_vld_rd_ff, b_vld_rd_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   idx_type                  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [ELEM_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in, rsp_err_ff, rsp_err_in;

   idx_type                  m_last, n_last, q_last;
   logic                     accept, load_a, load_b, a_oob, b_oob;
   addr_type                 wr_addr, a_raddr, b_raddr;
   logic [ELEM_W-1:0]        a_rdata, b_rdata;
   logic signed [ELEM_W-1:0] a_op, b_op;
   logic signed [SH_W-1:0]   acc_sh;
   logic [ELEM_W-1:0]        acc_sat;
   logic                     err_word, prod_word, compute_go;

   assign m_last  = dim_last(a_rows_ff);
   assign n_last  = dim_last(inner_dim_ff);
   assign q_last  = dim_last(b_cols_ff);
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign a_oob   = (req_elem_row > m_last) || (req_elem_col > n_last);
   assign b_oob   = (req_elem_row > n_last) || (req_elem_col > q_last);
   assign load_a  = accept && (req_type == REQ_LOAD_A) && !a_oob;
   assign load_b  = accept && (req_type == REQ_LOAD_B) && !b_oob;
   assign wr_addr = {req_elem_row, req_elem_col};
   assign a_raddr = {i_ff, k_ff};
   assign b_raddr = {k_ff, j_ff};

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   assign a_op = a_vld_rd_ff ? $signed(a_rdata) : '0;
   assign b_op = b_vld_rd_ff ? $signed(b_rdata) : '0;

   always_comb begin
      acc_sh = acc_ff[ACC_W-1:FRAC_BITS];
      if ((&acc_sh[SH_W-1:ELEM_W-1]) || !(|acc_sh[SH_W-1:ELEM_W-1])) begin
         acc_sat = acc_sh[ELEM_W-1:0];
      end else if (acc_sh[SH_W-1]) begin
         acc_sat = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_type == REQ_LOAD_A && a_oob) || (req_type == REQ_LOAD_B && b_oob)) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = req_elem_row;
                  rsp_col_in   = req_elem_col;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_err_in   = 1'b1;
               end else if (req_type == REQ_COMPUTE) begin
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (k_ff == n_last) begin
               state_in = ST_OUT;
            end else begin
               k_in     = k_ff + idx_type'(1);
               state_in = ST_RD;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = i_ff;
            rsp_col_in   = j_ff;
            rsp_value_in = acc_sat;
            rsp_last_in  = (i_ff == m_last) && (j_ff == q_last);
            rsp_err_in   = 1'b0;
            acc_in       = '0;
            k_in         = '0;
            state_in     = ST_RD;
            if (j_ff == q_last) begin
               j_in = '0;
               if (i_ff == m_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + idx_type'(1);
               end
            end else begin
               j_in = j_ff + idx_type'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_valid_ff   <= '0;
         b_valid_ff   <= '0;
         a_rows_ff    <= dim_reg_type'(1);
         inner_dim_ff <= dim_reg_type'(1);
         b_cols_ff    <= dim_reg_type'(1);
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         if (load_a) begin
            a_valid_ff[wr_addr] <= 1'b1;
         end
         if (load_b) begin
            b_valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_A_ROWS:    a_rows_ff    <= csr_data;
               CSR_INNER_DIM: inner_dim_ff <= csr_data;
               CSR_B_COLS:    b_cols_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      a_vld_rd_ff  <= a_valid_ff[a_raddr];
      b_vld_rd_ff  <= b_valid_ff[b_raddr];
      prod_ff      <= a_op * b_op;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_value   = $signed(rsp_value_ff);
   assign rsp_last_flag   = rsp_last_ff;
   assign rsp_index_error = rsp_err_ff;

   assign err_word   = rsp_valid && rsp_index_error;
   assign prod_word  = rsp_valid && !rsp_index_error;
   assign compute_go = accept && (req_type == REQ_COMPUTE);

   `MME_ASSERT_SAME(a_err_word, err_word, rsp_last_flag && (rsp_out_value == '0), "bad error word")
   `MME_ASSERT_SAME(a_err_idle, err_word, !busy, "error word while busy")
   `MME_ASSERT_SAME(a_last_done, prod_word && rsp_last_flag, !busy, "last word while busy")
   `MME_ASSERT_NEXT(a_cmp_start, compute_go, busy && k_ff == '0 && acc_ff == '0, "dirty start")
   `MME_ASSERT_SAME(a_word_src, prod_word, $past(state_ff) == ST_OUT, "word not from output step")

endmodule

@@ tb/sv/mme_scoreboard.sv @@
// ----------------------------------------------------------------------------
// mme_scoreboard
// Watches the request, result and register ports of the matrix multiply
// engine. Keeps its own copy of both element stores and the dimension
// registers, works out the product words each accepted request must cause,
// and compares every result word field by field with the oldest one due.
// ----------------------------------------------------------------------------
module mme_scoreboard
   import mme_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_type,
   input  logic [DIM_W-1:0]         req_elem_row,
   input  logic [DIM_W-1:0]         req_elem_col,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   input  logic                     rsp_valid,
   input  logic [DIM_W-1:0]         rsp_out_row,
   input  logic [DIM_W-1:0]         rsp_out_col,
   input  logic signed [ELEM_W-1:0] rsp_out_value,
   input  logic                     rsp_last_flag,
   input  logic                     rsp_index_error,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_REG_W-1:0]     csr_data,
   output int unsigned              mismatches,
   output int unsigned              words_due
);

   typedef struct {
      idx_type           row;
      idx_type           col;
      logic [ELEM_W-1:0] value;
      logic              last;
      logic              err;
   } product_word_type;

   localparam logic signed [71:0] SAT_HIGH = 72'sh7FFFFFFF;
   localparam logic signed [71:0] SAT_LOW  = -72'sh80000000;

   logic signed [ELEM_W-1:0] a_elems [DEPTH];
   logic signed [ELEM_W-1:0] b_elems [DEPTH];
   dim_reg_type              rows_dim;
   dim_reg_type              inner_dim;
   dim_reg_type              cols_dim;
   product_word_type         product_queue [$];
   product_word_type         oldest;
   int unsigned              mismatch_tally;

   initial begin
      mismatches     = 0;
      words_due      = 0;
      mismatch_tally = 0;
   end

   function automatic int unsigned dim_span(input dim_reg_type v);
      if (v == '0) return 1;
      if (v > dim_reg_type'(MAX_DIM)) return MAX_DIM;
      return v;
   endfunction

   // exact dot product of row i of A and column j of B, scaled and saturated
   function automatic logic [ELEM_W-1:0] fixed_dot(input int unsigned i, input int unsigned j,
                                                   input int unsigned n);
      logic signed [71:0] sum;
      logic signed [71:0] scaled;
      sum = '0;
      for (int k = 0; k < n; k++) begin
         sum = sum + a_elems[i * MAX_DIM + k] * b_elems[k * MAX_DIM + j];
      end
      scaled = sum >>> FRAC_BITS;
      if (scaled > SAT_HIGH) return 32'h7FFF_FFFF;
      if (scaled < SAT_LOW) return 32'h8000_0000;
      return scaled[ELEM_W-1:0];
   endfunction

   task automatic predict_products(input logic [1:0] kind, input idx_type r, input idx_type c,
                                   input logic signed [ELEM_W-1:0] v);
      int unsigned      m;
      int unsigned      n;
      int unsigned      q;
      int unsigned      row_lim;
      int unsigned      col_lim;
      product_word_type w;
      m = dim_span(rows_dim);
      n = dim_span(inner_dim);
      q = dim_span(cols_dim);
      case (kind)
         REQ_LOAD_A, REQ_LOAD_B: begin
            row_lim = (kind == REQ_LOAD_A) ? m : n;
            col_lim = (kind == REQ_LOAD_A) ? n : q;
            if (r >= row_lim || c >= col_lim) begin
               w.row   = r;
               w.col   = c;
               w.value = '0;
               w.last  = 1'b1;
               w.err   = 1'b1;
               product_queue.push_back(w);
            end else if (kind == REQ_LOAD_A) begin
               a_elems[r * MAX_DIM + c] = v;
            end else begin
               b_elems[r * MAX_DIM + c] = v;
            end
         end
         REQ_COMPUTE: begin
            for (int i = 0; i < m; i++) begin
               for (int j = 0; j < q; j++) begin
                  w.row   = idx_type'(i);
                  w.col   = idx_type'(j);
                  w.value = fixed_dot(i, j, n);
                  w.last  = (i == m - 1) && (j == q - 1);
                  w.err   = 1'b0;
                  product_queue.push_back(w);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [ELEM_W-1:0] want,
                              input logic [ELEM_W-1:0] got);
      if (want !== got) begin
         $display("%0t %s expected %h actual %h", $time, name, want, got);
         mismatch_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         a_elems   = '{default: '0};
         b_elems   = '{default: '0};
         rows_dim  = dim_reg_type'(1);
         inner_dim = dim_reg_type'(1);
         cols_dim  = dim_reg_type'(1);
         product_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_A_ROWS:    rows_dim  = csr_data;
               CSR_INNER_DIM: inner_dim = csr_data;
               CSR_B_COLS:    cols_dim  = csr_data;
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            predict_products(req_type, req_elem_row, req_elem_col, req_elem_value);
         end
         if (rsp_valid) begin
            if (product_queue.size() == 0) begin
               $display("%0t unexpected word row %0d col %0d value %h expected none actual %h",
                        $time, rsp_out_row, rsp_out_col, rsp_out_value, rsp_out_value);
               mismatch_tally++;
            end else begin
               oldest = product_queue.pop_front();
               check_field("out_row", oldest.row, rsp_out_row);
               check_field("out_col", oldest.col, rsp_out_col);
               check_field("out_value", oldest.value, rsp_out_value);
               check_field("last_flag", oldest.last, rsp_last_flag);
               check_field("index_error", oldest.err, rsp_index_error);
            end
         end
      end
      words_due  <= product_queue.size();
      mismatches <= mismatch_tally;
   end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the matrix multiply engine with a short directed run (saturation
// both ways, rounding of small negatives, out-of-range loads, the unused
// request code, zero and oversized dimension registers) and then random
// phases that fill A and B at random sizes and compute their product, with
// random gaps on the request side. The scoreboard predicts and checks.
// ----------------------------------------------------------------------------
module tb_top
   import mme_pkg::*;
();

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET  = 305;
   localparam int         SETTLE       = 8;
   localparam int         CYCLE_LIMIT  = 2_000_000;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     start           = 1'b0;
   logic                     busy;
   logic [1:0]               req_type        = REQ_LOAD_A;
   logic [DIM_W-1:0]         req_elem_row    = '0;
   logic [DIM_W-1:0]         req_elem_col    = '0;
   logic signed [ELEM_W-1:0] req_elem_value  = '0;
   logic                     rsp_valid;
   logic [DIM_W-1:0]         rsp_out_row;
   logic [DIM_W-1:0]         rsp_out_col;
   logic signed [ELEM_W-1:0] rsp_out_value;
   logic                     rsp_last_flag;
   logic                     rsp_index_error;
   logic                     csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index       = CSR_A_ROWS;
   logic [DIM_REG_W-1:0]     csr_data        = '0;
   int unsigned              mismatches;
   int unsigned              words_due;
   int unsigned              words_issued    = 0;
   int unsigned              burst_left      = 1;
   int unsigned              cycle_count     = 0;

   matrix_multiply_engine dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_elem_row    (req_elem_row),
      .req_elem_col    (req_elem_col),
      .req_elem_value  (req_elem_value),
      .rsp_valid       (rsp_valid),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_flag   (rsp_last_flag),
      .rsp_index_error (rsp_index_error),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   mme_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_elem_row    (req_elem_row),
      .req_elem_col    (req_elem_col),
      .req_elem_value  (req_elem_value),
      .rsp_valid       (rsp_valid),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_flag   (rsp_last_flag),
      .rsp_index_error (rsp_index_error),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .words_due       (words_due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [ELEM_W-1:0] elem_pick();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      endcase
   endfunction

   function automatic int unsigned pick_span();
      if ($urandom_range(0, 5) == 0) return $urandom_range(5, MAX_DIM);
      return $urandom_range(1, 4);
   endfunction

   // encode a size, using the zero and oversized codes now and then
   function automatic dim_reg_type dim_code(input int unsigned n);
      if (n == 1 && $urandom_range(0, 2) == 0) return '0;
      if (n == MAX_DIM && $urandom_range(0, 2) == 0)
         return dim_reg_type'($urandom_range(MAX_DIM + 1, (1 << DIM_REG_W) - 1));
      return dim_reg_type'(n);
   endfunction

   task automatic issue_word(input logic [1:0] kind, input idx_type r, input idx_type c,
                             input logic [ELEM_W-1:0] v);
      start          <= 1'b1;
      req_type       <= kind;
      req_elem_row   <= r;
      req_elem_col   <= c;
      req_elem_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind != REQ_UNUSED) words_issued++;
      burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (words_due != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_dims(input dim_reg_type rows, input dim_reg_type inner,
                               input dim_reg_type cols);
      hold_until_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_A_ROWS;
      csr_data  <= rows;
      @(posedge clock);
      csr_index <= CSR_INNER_DIM;
      csr_data  <= inner;
      @(posedge clock);
      csr_index <= CSR_B_COLS;
      csr_data  <= cols;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic inject_noise();
      case ($urandom_range(0, 2))
         0: issue_word(REQ_UNUSED, idx_type'($urandom_range(0, 7)),
                       idx_type'($urandom_range(0, 7)), $urandom());
         1: issue_word($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
                       idx_type'($urandom_range(0, 7)), idx_type'($urandom_range(0, 7)),
                       elem_pick());
         default: issue_word(REQ_COMPUTE, idx_type'($urandom_range(0, 7)),
                             idx_type'($urandom_range(0, 7)), $urandom());
      endcase
   endtask

   task automatic run_random_phase();
      int unsigned rows_n;
      int unsigned inner_n;
      int unsigned cols_n;
      rows_n  = pick_span();
      inner_n = pick_span();
      cols_n  = pick_span();
      program_dims(dim_code(rows_n), dim_code(inner_n), dim_code(cols_n));
      repeat ($urandom_range(1, 3)) begin
         for (int i = 0; i < rows_n; i++) begin
            for (int k = 0; k < inner_n; k++) begin
               if (words_issued < ITEM_TARGET && $urandom_range(0, 9) == 0) inject_noise();
               if (words_issued < ITEM_TARGET && $urandom_range(0, 5) != 0)
                  issue_word(REQ_LOAD_A, idx_type'(i), idx_type'(k), elem_pick());
            end
         end
         for (int k = 0; k < inner_n; k++) begin
            for (int j = 0; j < cols_n; j++) begin
               if (words_issued < ITEM_TARGET && $urandom_range(0, 9) == 0) inject_noise();
               if (words_issued < ITEM_TARGET && $urandom_range(0, 5) != 0)
                  issue_word(REQ_LOAD_B, idx_type'(k), idx_type'(j), elem_pick());
            end
         end
         issue_word(REQ_COMPUTE, idx_type'($urandom_range(0, 7)),
                    idx_type'($urandom_range(0, 7)), $urandom());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue_word(REQ_COMPUTE, '0, '0, '0);
      issue_word(REQ_LOAD_A, '0, '0, 32'h7FFF_FFFF);
      issue_word(REQ_LOAD_B, '0, '0, 32'h7FFF_FFFF);
      issue_word(REQ_COMPUTE, '0, '0, '0);
      issue_word(REQ_LOAD_A, '0, '0, 32'h8000_0000);
      issue_word(REQ_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      issue_word(REQ_LOAD_A, '0, '0, 32'hFFFF_FFFF);
      issue_word(REQ_LOAD_B, '0, '0, 32'h0000_0001);
      issue_word(REQ_COMPUTE, '0, '0, '0);
      issue_word(REQ_LOAD_A, '0, 3'd1, 32'h1234_5678);
      issue_word(REQ_LOAD_B, 3'd1, '0, 32'h1234_5678);
      issue_word(REQ_LOAD_A, 3'd7, 3'd7, 32'hFFFF_FFFF);
      issue_word(REQ_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
      issue_word(REQ_UNUSED, 3'd5, 3'd5, 32'hA5A5_A5A5);

      program_dims(4'd0, 4'd15, 4'd9);
      issue_word(REQ_LOAD_A, '0, 3'd7, 32'h0002_0000);
      issue_word(REQ_LOAD_B, 3'd7, 3'd7, 32'h0003_0000);
      issue_word(REQ_LOAD_B, 3'd7, '0, 32'h8000_0000);
      issue_word(REQ_LOAD_A, 3'd1, '0, 32'h0001_0000);
      issue_word(REQ_COMPUTE, '0, '0, '0);

      program_dims(4'd8, 4'd8, 4'd8);
      issue_word(REQ_COMPUTE, '0, '0, '0);

      while (words_issued < ITEM_TARGET) run_random_phase();

      hold_until_drained();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
